>>> rtl/okvt_pkg.sv
// shared types, codes and defaults for the ordered key-value table
`default_nettype none

package okvt_pkg;

    localparam int TYPE_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam int CAPACITY_DEF    = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [TYPE_W-1:0] REQ_LOOKUP = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_UPSERT = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/okvt_if.sv
// request and response channel interfaces
`default_nettype none

interface okvt_req_if;
    logic                                valid;
    logic                                ready;
    logic [okvt_pkg::TYPE_W-1:0]         req_type;
    logic [okvt_pkg::FIELD_W-1:0]        req_key;
    logic [okvt_pkg::FIELD_W-1:0]        req_value;
    logic [okvt_pkg::POS_W-1:0]          req_position;

    modport source (output valid, req_type, req_key, req_value, req_position,
                    input ready);
    modport sink (input valid, req_type, req_key, req_value, req_position,
                  output ready);
endinterface

interface okvt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                succeeded;
    logic [okvt_pkg::STATUS_W-1:0]       status;
    logic [okvt_pkg::FIELD_W-1:0]        out_key;
    logic [okvt_pkg::FIELD_W-1:0]        out_value;
    logic [okvt_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, succeeded, status, out_key, out_value, entry_count,
                    input ready);
    modport sink (input valid, succeeded, status, out_key, out_value, entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/okvt_ctrl.sv
// request sequencer: accepts a beat, runs the table cycle, holds the response valid
`default_nettype none

module okvt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output okvt_pkg::ctl_cmd_t     cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && rst_n)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // no beat is taken while reset is held
    assign in_ready  = (state_reg == S_IDLE) && rst_n;
    assign out_valid = out_valid_reg;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an accepted beat");

    a_exec_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("response not valid after the table cycle");

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid || out_ready))
        else $error("table cycle overwrote a waiting response");

endmodule

`default_nettype wire

>>> rtl/okvt_dp.sv
// entry registers, parallel key compare, shift-down erase and response register
`default_nettype none

module okvt_dp #(
    parameter int CAPACITY    = okvt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = okvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = okvt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire okvt_pkg::ctl_cmd_t            cmd,
    input  wire logic [okvt_pkg::TYPE_W-1:0]   req_type,
    input  wire logic [okvt_pkg::FIELD_W-1:0]  req_key,
    input  wire logic [okvt_pkg::FIELD_W-1:0]  req_value,
    input  wire logic [okvt_pkg::POS_W-1:0]    req_position,
    output logic                               succeeded,
    output logic [okvt_pkg::STATUS_W-1:0]      status,
    output logic [okvt_pkg::FIELD_W-1:0]       out_key,
    output logic [okvt_pkg::FIELD_W-1:0]       out_value,
    output logic [okvt_pkg::COUNT_W-1:0]       entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [okvt_pkg::TYPE_W-1:0] type_reg;
    logic [KEY_WIDTH-1:0]        key_reg;
    logic [VALUE_WIDTH-1:0]      value_reg;
    logic [okvt_pkg::POS_W-1:0]  pos_reg;

    logic [KEY_WIDTH-1:0]        keys_reg   [CAPACITY];
    logic [VALUE_WIDTH-1:0]      values_reg [CAPACITY];
    logic [CW-1:0]               count_reg, count_next;

    logic                        succeeded_reg;
    logic [okvt_pkg::STATUS_W-1:0] status_reg;
    logic [okvt_pkg::FIELD_W-1:0]  out_key_reg;
    logic [okvt_pkg::FIELD_W-1:0]  out_value_reg;
    logic [okvt_pkg::COUNT_W-1:0]  entry_count_reg;

    logic [CAPACITY-1:0]         match;
    logic                        hit;
    logic [IW-1:0]               hit_idx;
    logic [IW-1:0]               rd_idx;
    logic [IW-1:0]               tail_idx;
    logic                        pos_ok;
    logic                        full;
    logic [KEY_WIDTH-1:0]        rd_key;
    logic [VALUE_WIDTH-1:0]      rd_value;

    logic                        ok;
    logic [okvt_pkg::STATUS_W-1:0] st;
    logic [okvt_pkg::FIELD_W-1:0]  okey;
    logic [okvt_pkg::FIELD_W-1:0]  oval;
    logic                        do_update;
    logic                        do_append;
    logic                        do_erase;

    // parallel compare across the valid entries
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (32'(i) < 32'(count_reg)) && (keys_reg[i] == key_reg);
            if (match[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    assign hit      = |match;
    assign pos_ok   = 32'(pos_reg) < 32'(count_reg);
    assign full     = (32'(count_reg) >= 32'(CAPACITY));
    assign tail_idx = IW'(count_reg);
    assign rd_idx   = (type_reg == okvt_pkg::REQ_READ) ? IW'(pos_reg) : hit_idx;
    assign rd_key   = keys_reg[rd_idx];
    assign rd_value = values_reg[rd_idx];

    always_comb
    begin
        ok         = 1'b0;
        st         = okvt_pkg::ST_OK;
        okey       = '0;
        oval       = '0;
        do_update  = 1'b0;
        do_append  = 1'b0;
        do_erase   = 1'b0;
        count_next = count_reg;
        unique case (type_reg) inside
            okvt_pkg::REQ_READ:
            begin
                if (pos_ok)
                begin
                    ok   = 1'b1;
                    okey = okvt_pkg::FIELD_W'(rd_key);
                    oval = okvt_pkg::FIELD_W'(rd_value);
                end
                else
                begin
                    st = okvt_pkg::ST_BAD_POS;
                end
            end
            okvt_pkg::REQ_ERASE:
            begin
                if (hit)
                begin
                    ok         = 1'b1;
                    do_erase   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    st = okvt_pkg::ST_NOT_FOUND;
                end
            end
            okvt_pkg::REQ_INSERT, okvt_pkg::REQ_UPDATE, okvt_pkg::REQ_UPSERT:
            begin
                if (hit)
                begin
                    if (type_reg == okvt_pkg::REQ_INSERT)
                    begin
                        st = okvt_pkg::ST_PRESENT;
                    end
                    else
                    begin
                        ok        = 1'b1;
                        do_update = 1'b1;
                    end
                end
                else if (type_reg == okvt_pkg::REQ_UPDATE)
                begin
                    st = okvt_pkg::ST_NOT_FOUND;
                end
                else if (full)
                begin
                    st = okvt_pkg::ST_FULL;
                end
                else
                begin
                    ok         = 1'b1;
                    do_append  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                if (hit)
                begin
                    ok   = 1'b1;
                    oval = okvt_pkg::FIELD_W'(rd_value);
                end
                else
                begin
                    st = okvt_pkg::ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= (req_type > okvt_pkg::REQ_READ) ? okvt_pkg::REQ_LOOKUP : req_type;
            key_reg   <= KEY_WIDTH'(req_key);
            value_reg <= VALUE_WIDTH'(req_value);
            pos_reg   <= req_position;
        end
        if (cmd.exec)
        begin
            succeeded_reg   <= ok;
            status_reg      <= st;
            out_key_reg     <= okey;
            out_value_reg   <= oval;
            entry_count_reg <= okvt_pkg::COUNT_W'(count_next);
            if (do_update)
            begin
                values_reg[hit_idx] <= value_reg;
            end
            if (do_append)
            begin
                keys_reg[tail_idx]   <= key_reg;
                values_reg[tail_idx] <= value_reg;
            end
            if (do_erase)
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (IW'(i) >= hit_idx)
                    begin
                        keys_reg[i]   <= keys_reg[i + 1];
                        values_reg[i] <= values_reg[i + 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign succeeded   = succeeded_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_value_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_append) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the table");

    a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_erase) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("erase did not shrink the table");

    a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $onehot0(match))
        else $error("key held at more than one position");

endmodule

`default_nettype wire

>>> rtl/ordered_key_value_table.sv
// Ordered key-value table: up to CAPACITY unique keys kept in insertion order, with
// lookup, insert, update, insert-or-update, erase (later entries move down one place)
// and read by position. Each request beat is first registered; then every valid entry
// is compared against the key at once and the table is written back, erase shifting
// all later entries in that same cycle, once any earlier response has been taken. The
// response sits in an output register, so a new request is taken while it waits;
// the next request is not taken until the table step of the current one is done.
`default_nettype none

module ordered_key_value_table #(
    parameter int CAPACITY    = okvt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = okvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = okvt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    okvt_req_if.sink   req,
    okvt_rsp_if.source rsp
);

    okvt_pkg::ctl_cmd_t cmd;

    okvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    okvt_dp #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .req_key      (req.req_key),
        .req_value    (req.req_value),
        .req_position (req.req_position),
        .succeeded    (rsp.succeeded),
        .status       (rsp.status),
        .out_key      (rsp.out_key),
        .out_value    (rsp.out_value),
        .entry_count  (rsp.entry_count)
    );

endmodule

`default_nettype wire
